FILE: hdl/assert_macros.svh
// Assertion macros shared by the rolling return volatility files.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define RRV_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RRV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RRV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rrv_pkg.sv
// Package for the rolling return volatility block: sizes, state types and
// the request struct to the statistics engine. No dependencies.
package rrv_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int AW         = $clog2(MAX_WINDOW);
  localparam int NW         = 7;
  localparam int PRICE_W    = 32;
  localparam int RET_W      = 32;
  localparam int FRAC_BITS  = 30;
  localparam int S1_W       = 38;
  localparam int S2_W       = 69;
  localparam int WIDE_W     = 76;
  localparam int DD_W       = 12;
  localparam int ROOT_STEPS = 32;
  localparam int SQ_HALF    = 19;

  localparam logic [NW-1:0] WIN_RESET = NW'(20);
  localparam logic [NW-1:0] WIN_MIN   = NW'(2);
  localparam logic [NW-1:0] WIN_MAX   = NW'(MAX_WINDOW);
  localparam logic [NW-1:0] SEEN_MAX  = NW'(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_RET,
    TS_WR,
    TS_CALC,
    TS_STAT,
    TS_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    SS_IDLE,
    SS_SUM,
    SS_SCALE,
    SS_SQ,
    SS_DIFF,
    SS_DIV,
    SS_RINIT,
    SS_ROOT,
    SS_DONE
  } stat_state_t;

  typedef struct packed {
    logic          start;
    logic [NW-1:0] n;
    logic [AW-1:0] wp;
  } stat_req_t;

endpackage

FILE: hdl/rrv_ring.sv
// Return ring: one write port, one registered read port.
// Depends on rrv_pkg.
module rrv_ring import rrv_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [RET_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [RET_W-1:0] rdata_r
);

  logic [RET_W-1:0] mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: hdl/rrv_ret.sv
// Serial divider forming the Q2.30 simple return of a close against the last.
// Depends on rrv_pkg.
module rrv_ret import rrv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [PRICE_W-1:0] c,
  input  logic [PRICE_W-1:0] p,
  output logic               done,
  output logic [RET_W-1:0]   ret,
  output logic               sat
);

  logic               busy_r;
  logic               done_r;
  logic [4:0]         cnt_r;
  logic [PRICE_W-1:0] rem_r;
  logic [PRICE_W-1:0] p_r;
  logic [RET_W-2:0]   q_r;
  logic               neg_r;
  logic               sat_r;

  logic               neg;
  logic [PRICE_W-1:0] d;
  logic               big;
  logic               ge0;
  logic [PRICE_W:0]   rem2;
  logic               ge;

  assign neg  = c < p;
  assign d    = neg ? p - c : c - p;
  assign big  = {1'b0, d} >= {p, 1'b0};
  assign ge0  = d >= p;
  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, p_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (big) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_r   <= p;
      neg_r <= neg & ~big;
      sat_r <= big;
      if (big) begin
        q_r <= '1;
      end else begin
        q_r   <= (RET_W-1)'(ge0);
        rem_r <= ge0 ? d - p : d;
      end
    end else if (busy_r) begin
      q_r   <= {q_r[RET_W-3:0], ge};
      rem_r <= ge ? PRICE_W'(rem2 - {1'b0, p_r}) : rem2[PRICE_W-1:0];
    end
  end

  assign done = done_r;
  assign sat  = sat_r;
  assign ret  = neg_r ? RET_W'(-{1'b0, q_r}) : {1'b0, q_r};

endmodule

FILE: hdl/rrv_stat.sv
// Statistics engine: walks the ring for the sums, then the variance division
// and the integer square root. Depends on rrv_pkg and the ring read port.
module rrv_stat import rrv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  stat_req_t        req,
  output logic [AW-1:0]    rd_addr,
  input  logic [RET_W-1:0] rd_data,
  output logic             done,
  output logic [31:0]      vol
);

  stat_state_t st_r, st_nxt;

  logic [NW-1:0]       n_r;
  logic [AW-1:0]       wp_r;
  logic [NW-1:0]       k_r;
  logic                v1_r, v2_r, v3_r;
  logic signed [S1_W-1:0] s1_r;
  logic [RET_W-1:0]    m_r;
  logic [2*RET_W-1:0]  prod_r;
  logic [S2_W-1:0]     s2_r;
  logic [S1_W-1:0]     mag_r;
  logic [WIDE_W-1:0]   acc_r;
  logic [WIDE_W-1:0]   sq_r;
  logic [WIDE_W-1:0]   quo_r;
  logic [DD_W-1:0]     rem_r;
  logic [DD_W-1:0]     dd_r;
  logic [6:0]          cnt_r;
  logic [63:0]         v_r, res_r, bit_r;

  logic                issue;
  logic                sum_end;
  logic [SQ_HALF-1:0]  mul_a, mul_b;
  logic [2*SQ_HALF-1:0] mul_p;
  logic [WIDE_W-1:0]   mul_sh;
  logic [DD_W:0]       rem2;
  logic                dge;
  logic [63:0]         rt;
  logic [NW-1:0]       nm1;

  assign issue   = (st_r == SS_SUM) && (k_r < n_r);
  assign sum_end = (k_r == n_r) && !v1_r && !v2_r && !v3_r;
  assign rd_addr = wp_r - AW'(1) - k_r[AW-1:0];
  assign rem2    = {rem_r, quo_r[WIDE_W-1]};
  assign dge     = rem2 >= {1'b0, dd_r};
  assign rt      = res_r + bit_r;
  assign nm1     = n_r - NW'(1);

  always_comb begin
    mul_a  = mag_r[SQ_HALF-1:0];
    mul_b  = mag_r[SQ_HALF-1:0];
    mul_sh = '0;
    case (cnt_r[1:0])
      2'd0: begin
        mul_sh = WIDE_W'(mul_p);
      end
      2'd1: begin
        mul_a  = mag_r[S1_W-1:SQ_HALF];
        mul_sh = WIDE_W'(mul_p) << (SQ_HALF + 1);
      end
      default: begin
        mul_a  = mag_r[S1_W-1:SQ_HALF];
        mul_b  = mag_r[S1_W-1:SQ_HALF];
        mul_sh = WIDE_W'(mul_p) << (2 * SQ_HALF);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    case (st_r)
      SS_IDLE:  if (req.start) st_nxt = SS_SUM;
      SS_SUM:   if (sum_end) st_nxt = SS_SCALE;
      SS_SCALE: st_nxt = SS_SQ;
      SS_SQ:    if (cnt_r[1:0] == 2'd2) st_nxt = SS_DIFF;
      SS_DIFF:  st_nxt = SS_DIV;
      SS_DIV:   if (cnt_r == 7'(WIDE_W - 1)) st_nxt = SS_RINIT;
      SS_RINIT: st_nxt = SS_ROOT;
      SS_ROOT:  if (cnt_r == 7'(ROOT_STEPS - 1)) st_nxt = SS_DONE;
      SS_DONE: begin
        done   = 1'b1;
        st_nxt = SS_IDLE;
      end
      default:  st_nxt = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      s1_r <= s1_r + S1_W'(signed'(rd_data));
      m_r  <= rd_data[RET_W-1] ? RET_W'(-rd_data) : rd_data;
    end
    if (v2_r) begin
      prod_r <= m_r * m_r;
    end
    if (v3_r) begin
      s2_r <= s2_r + S2_W'(prod_r);
    end
    case (st_r)
      SS_IDLE: begin
        if (req.start) begin
          n_r  <= req.n;
          wp_r <= req.wp;
          k_r  <= '0;
          s1_r <= '0;
          s2_r <= '0;
        end
      end
      SS_SUM: begin
        if (issue) k_r <= k_r + NW'(1);
      end
      SS_SCALE: begin
        acc_r <= WIDE_W'(s2_r) * WIDE_W'(n_r);
        mag_r <= s1_r[S1_W-1] ? S1_W'(-s1_r) : S1_W'(s1_r);
        sq_r  <= '0;
        cnt_r <= '0;
      end
      SS_SQ: begin
        sq_r  <= sq_r + mul_sh;
        cnt_r <= cnt_r + 7'd1;
      end
      SS_DIFF: begin
        quo_r <= acc_r - sq_r;
        rem_r <= '0;
        dd_r  <= DD_W'(n_r) * DD_W'(nm1);
        cnt_r <= '0;
      end
      SS_DIV: begin
        rem_r <= dge ? DD_W'(rem2 - {1'b0, dd_r}) : rem2[DD_W-1:0];
        quo_r <= {quo_r[WIDE_W-2:0], dge};
        cnt_r <= cnt_r + 7'd1;
      end
      SS_RINIT: begin
        v_r   <= quo_r[63:0];
        res_r <= '0;
        bit_r <= 64'd1 << 62;
        cnt_r <= '0;
      end
      SS_ROOT: begin
        if (v_r >= rt) begin
          v_r   <= v_r - rt;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 7'd1;
      end
      default: begin
      end
    endcase
  end

  assign vol = res_r[31:0];

endmodule

FILE: hdl/rolling_return_volatility.sv
// Top level of the rolling return volatility block: control sequencer,
// ring, return divider and statistics engine. Depends on rrv_pkg and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_close_price
//   out      output     out_valid/out_stall  volatility, ready, flags
//   cfg      input      cfg_write_enable     cfg_write_data (window length)
//
// Before the window is full an item goes through at most the return divider;
// once full it also goes through the ring walk, the 76-step variance
// division and the 32-step square root.
// Reset clears control state; the ring needs no clearing pass.
// A request is taken only in idle; a held result blocks only the next result.
`include "assert_macros.svh"
module rolling_return_volatility import rrv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PRICE_W-1:0] in_close_price,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_volatility,
  output logic               out_ready_res,
  output logic               out_zero_price_flag,
  output logic               out_return_saturated,
  input  logic               cfg_write_enable,
  input  logic [NW-1:0]      cfg_write_data
);

  top_state_t st_r, st_nxt;

  logic [NW-1:0]      win_r;
  logic [PRICE_W-1:0] prev_r;
  logic [PRICE_W-1:0] c_r;
  logic [AW-1:0]      wp_r;
  logic [NW-1:0]      seen_r;
  logic [RET_W-1:0]   r_r;
  logic               z_r, s_r, rdy_r;
  logic [31:0]        vol_r;
  logic               out_valid_r;

  logic               accept;
  logic               ret_start;
  logic               ret_done;
  logic [RET_W-1:0]   ret_val;
  logic               ret_sat;
  logic [NW-1:0]      n_eff;
  logic [NW-1:0]      seen_inc;
  logic               ready_now;
  logic               out_free;
  stat_req_t          sreq;
  logic [AW-1:0]      rd_addr;
  logic [RET_W-1:0]   rd_data;
  logic               stat_done;
  logic [31:0]        stat_vol;

  assign in_stall  = (st_r != TS_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign n_eff     = (win_r < WIN_MIN) ? WIN_MIN : ((win_r > WIN_MAX) ? WIN_MAX : win_r);
  assign seen_inc  = (seen_r == SEEN_MAX) ? seen_r : seen_r + NW'(1);
  assign ready_now = {1'b0, seen_inc} >= ({1'b0, n_eff} + (NW+1)'(1));
  assign ret_start = accept && (seen_r != '0) && (prev_r != '0);

  assign sreq.start = (st_r == TS_CALC) && ready_now;
  assign sreq.n     = n_eff;
  assign sreq.wp    = wp_r;

  rrv_ring u_ring (
    .clk     (clk),
    .we      (st_r == TS_WR),
    .waddr   (wp_r),
    .wdata   (r_r),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  rrv_ret u_ret (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ret_start),
    .c     (in_close_price),
    .p     (prev_r),
    .done  (ret_done),
    .ret   (ret_val),
    .sat   (ret_sat)
  );

  rrv_stat u_stat (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sreq),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (stat_done),
    .vol     (stat_vol)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      TS_IDLE: begin
        if (accept) begin
          if (seen_r == '0) begin
            st_nxt = TS_CALC;
          end else if (prev_r == '0) begin
            st_nxt = TS_WR;
          end else begin
            st_nxt = TS_RET;
          end
        end
      end
      TS_RET:  if (ret_done) st_nxt = TS_WR;
      TS_WR:   st_nxt = TS_CALC;
      TS_CALC: st_nxt = ready_now ? TS_STAT : TS_OUT;
      TS_STAT: if (stat_done) st_nxt = TS_OUT;
      TS_OUT:  if (out_free) st_nxt = TS_IDLE;
      default: st_nxt = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_RESET;
      prev_r      <= '0;
      wp_r        <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_enable) win_r <= cfg_write_data;
      if (st_r == TS_WR) wp_r <= wp_r + AW'(1);
      if (st_r == TS_CALC) begin
        prev_r <= c_r;
        seen_r <= seen_inc;
      end
      if (st_r == TS_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_r <= in_close_price;
      r_r <= '0;
      z_r <= (seen_r != '0) && (prev_r == '0);
      s_r <= 1'b0;
    end
    if (st_r == TS_RET && ret_done) begin
      r_r <= ret_val;
      s_r <= ret_sat;
    end
    if (st_r == TS_CALC) begin
      rdy_r <= ready_now;
      vol_r <= '0;
    end
    if (st_r == TS_STAT && stat_done) vol_r <= stat_vol;
    if (st_r == TS_OUT && out_free) begin
      out_volatility       <= vol_r;
      out_ready_res        <= rdy_r;
      out_zero_price_flag  <= z_r;
      out_return_saturated <= s_r;
    end
  end

  assign out_valid = out_valid_r;

  `RRV_ASSERT_NEXT(a_accept_busy, accept, st_r != TS_IDLE, "request taken but sequencer idle")
  `RRV_ASSERT_IMP(a_not_ready_zero, out_valid && !out_ready_res, out_volatility == '0, "volatility without ready")
  `RRV_ASSERT(a_flags_excl, !(out_valid && out_zero_price_flag && out_return_saturated), "zero and saturation flags together")
  `RRV_ASSERT_IMP(a_stat_done_state, stat_done, st_r == TS_STAT, "statistics done outside wait")

endmodule

FILE: tb/sv/rrv_checker.sv
// Result checker for rolling_return_volatility: tracks the window register,
// predicts volatility and flags per accepted request, compares results.
// Depends on rrv_pkg.
`timescale 1ns / 100ps
module rrv_checker import rrv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [PRICE_W-1:0] in_close_price,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        out_volatility,
  input  logic               out_ready_res,
  input  logic               out_zero_price_flag,
  input  logic               out_return_saturated,
  input  logic               cfg_write_enable,
  input  logic [NW-1:0]      cfg_write_data,
  output int                 fail_count,
  output int                 pending,
  output int                 ready_count,
  output int                 sat_count,
  output int                 zero_count
);

  typedef struct {
    logic [31:0] vol;
    logic        ready;
    logic        zero_prev;
    logic        sat;
  } vol_result_t;

  vol_result_t    vol_expected_q[$];
  logic [NW-1:0]  window_reg;
  logic [31:0]    last_close;
  logic [RET_W-1:0] returns[MAX_WINDOW];
  int unsigned    ret_wp;
  int unsigned    seen;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic vol_result_t predict_volatility(input logic [31:0] c);
    vol_result_t     r;
    int unsigned     n, idx;
    logic [63:0]     d, q, p;
    logic [31:0]     ret, raw;
    logic signed [63:0] s1;
    logic [127:0]    s2, mag, num, quo;
    logic [63:0]     root;
    r = '{default: 0};
    n = window_reg;
    if (n < WIN_MIN) n = WIN_MIN;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    if (seen > 0) begin
      ret = 0;
      p = last_close;
      if (p == 0) begin
        r.zero_prev = 1;
      end else begin
        d = (c < p) ? p - c : c - p;
        if (d / p >= 2) begin
          r.sat = 1;
          ret = 32'h7FFF_FFFF;
        end else begin
          q = (d << FRAC_BITS) / p;
          ret = (c < p) ? 32'(-q) : q[31:0];
        end
      end
      returns[ret_wp] = ret;
      ret_wp = (ret_wp + 1) % MAX_WINDOW;
    end
    last_close = c;
    if (seen < MAX_WINDOW + 1) seen++;
    if (seen >= n + 1) begin
      r.ready = 1;
      s1 = 0;
      s2 = 0;
      for (int k = 0; k < n; k++) begin
        idx = (ret_wp + MAX_WINDOW - 1 - k) % MAX_WINDOW;
        raw = returns[idx];
        s1 = s1 + 64'(signed'(raw));
        s2 = s2 + 128'(64'(signed'(raw)) * 64'(signed'(raw)));
      end
      mag = (s1 < 0) ? 128'(-s1) : 128'(s1);
      num = s2 * n - mag * mag;
      quo = num / (n * (n - 1));
      root = floor_sqrt(quo[63:0]);
      r.vol = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    vol_result_t e;
    if (!rst_n) begin
      vol_expected_q.delete();
      window_reg = WIN_RESET;
      last_close = 0;
      ret_wp = 0;
      seen = 0;
      fail_count = 0;
      ready_count = 0;
      sat_count = 0;
      zero_count = 0;
    end else begin
      if (cfg_write_enable) window_reg = cfg_write_data;
      if (in_valid && !in_stall) begin
        e = predict_volatility(in_close_price);
        vol_expected_q = {vol_expected_q, e};
      end
      if (out_valid && !out_stall) begin
        if (vol_expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = vol_expected_q.pop_front();
          if (out_volatility !== e.vol) begin
            $error("volatility: expected %h, got %h", e.vol, out_volatility);
            fail_count++;
          end
          if (out_ready_res !== e.ready) begin
            $error("ready_res: expected %b, got %b", e.ready, out_ready_res);
            fail_count++;
          end
          if (out_zero_price_flag !== e.zero_prev) begin
            $error("zero_price_flag: expected %b, got %b", e.zero_prev, out_zero_price_flag);
            fail_count++;
          end
          if (out_return_saturated !== e.sat) begin
            $error("return_saturated: expected %b, got %b", e.sat, out_return_saturated);
            fail_count++;
          end
          ready_count += e.ready;
          sat_count += e.sat;
          zero_count += e.zero_prev;
        end
      end
    end
    pending = vol_expected_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Top of the rolling_return_volatility testbench: clock, reset, close price
// stimulus, window writes and verdict. Depends on rrv_pkg, rrv_checker and the DUT.
`timescale 1ns / 100ps
module tb;
  import rrv_pkg::*;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [PRICE_W-1:0] in_close_price = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [31:0]        out_volatility;
  logic               out_ready_res;
  logic               out_zero_price_flag;
  logic               out_return_saturated;
  logic               cfg_write_enable = 0;
  logic [NW-1:0]      cfg_write_data = 0;
  logic               in_taken = 0;
  int                 fail_count, pending, ready_count, sat_count, zero_count;
  int                 send_idle_pct = 0, stall_pct = 0;
  int                 request_count = 0;
  logic [31:0]        prev_price = 0;

  localparam logic [NW-1:0] WIN_PLAN[12] = '{
    NW'(2), NW'(64), NW'(127), NW'(0), NW'(20), NW'(1),
    NW'(65), NW'(3), NW'(33), NW'(64), NW'(2), NW'(47)
  };
  localparam logic [31:0] DIRECTED[24] = '{
    32'd100, 32'd0, 32'd0, 32'd500, 32'd1500, 32'd1499, 32'hFFFF_FFFF, 32'd1,
    32'hFFFF_FFFF, 32'd0, 32'd7, 32'd8, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3,
    32'd9, 32'd2, 32'd5, 32'd1, 32'd1, 32'hAAAA_AAAA, 32'h5555_5555, 32'd4, 32'd3
  };

  always #10 clk = ~clk;

  rolling_return_volatility dut (.*);

  rrv_checker u_checker (.*);

  always @(posedge clk) in_taken <= in_valid && !in_stall;

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_close(input logic [31:0] price);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1;
    in_close_price <= price;
    do @(negedge clk); while (!in_taken);
    prev_price = price;
    request_count++;
  endtask

  task automatic write_window(input logic [NW-1:0] w);
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    cfg_write_enable <= 1;
    cfg_write_data <= w;
    @(negedge clk);
    cfg_write_enable <= 0;
  endtask

  function automatic logic [31:0] next_price();
    logic [31:0] delta;
    case ($urandom_range(19))
      0:       return 0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      4:       return prev_price * 3 + $urandom_range(5);
      5:       return $urandom_range(1, 16);
      default: begin
        if (prev_price < 1000) return $urandom_range(1000, 32'h7FFF_FFFF);
        delta = prev_price >> $urandom_range(3, 12);
        delta = $urandom_range(0, delta);
        return $urandom_range(1) ? prev_price + delta : prev_price - delta;
      end
    endcase
  endfunction

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1;
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph < 4) ? 36 : (ph < 8) ? 67 : 0;
      stall_pct = (ph < 4) ? 67 : (ph < 8) ? 36 : 0;
      write_window(WIN_PLAN[ph]);
      if (ph == 0) begin
        foreach (DIRECTED[i]) send_close(DIRECTED[i]);
      end
      for (int i = 0; i < 44; i++) send_close(next_price());
    end
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Sent %0d close prices over 12 window settings (including out-of-range values);",
             request_count);
    $display("%0d ready results, %0d clamped returns, %0d zero previous closes.",
             ready_count, sat_count, zero_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/rrv_pkg.sv
hdl/rrv_ring.sv
hdl/rrv_ret.sv
hdl/rrv_stat.sv
hdl/rolling_return_volatility.sv
tb/sv/rrv_checker.sv
tb/sv/tb.sv
